// ===== rtl/aabb_collision_table_top_defines.svh =====
// Assertion macros shared by the box table RTL.
// Depends on nothing; users must have signals named clk and rst in scope.
`ifndef AABB_COLLISION_TABLE_TOP_DEFINES_SVH
`define AABB_COLLISION_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define AABB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define AABB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/aabb_ct_pkg.sv =====
// Types and constants for the box table with overlap search.
// Used by the overlap unit and the top level; depends on nothing.
package aabb_ct_pkg;

  localparam int COORD_W  = 16;
  localparam int SCALE_W  = 9;
  localparam int FRAC_W   = 8;
  localparam int KIND_W   = 2;
  localparam int IDX_W    = 6;
  localparam int STATUS_W = 2;
  localparam int ECNT_W   = 7;
  localparam int PROD_W   = COORD_W + SCALE_W;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int SUM_W    = PROD_W + 1;
  localparam int BOX_W    = 4 * COORD_W;
  localparam int IN_DATA_W  = ((IDX_W + BOX_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((STATUS_W + 1 + IDX_W + ECNT_W + 7) / 8) * 8;

  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FIND   = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

  localparam logic REG_X_SCALE = 1'b0;
  localparam logic REG_Y_SCALE = 1'b1;

  localparam logic [SCALE_W-1:0] X_SCALE_RESET = 9'd243;
  localparam logic [SCALE_W-1:0] Y_SCALE_RESET = 9'd205;

  typedef struct packed {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic [COORD_W-1:0]        sx;
    logic [COORD_W-1:0]        sy;
  } box_t;

  typedef struct packed {
    logic valid;
    logic load_q;
  } ovl_ctl_t;

  typedef struct packed {
    logic valid;
    logic hit;
  } ovl_res_t;

endpackage

// ===== rtl/aabb_ct_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module aabb_ct_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/aabb_ct_ovl.sv =====
// Shared overlap unit: one multiplier pair, then an abs-distance compare per axis.
// Depends on aabb_ct_pkg.
module aabb_ct_ovl import aabb_ct_pkg::*; #(
  parameter int TAG_W = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  ovl_ctl_t           ctl,
  input  box_t               ent,
  input  logic [TAG_W-1:0]   ent_idx,
  input  box_t               query,
  input  logic [SCALE_W-1:0] x_scale,
  input  logic [SCALE_W-1:0] y_scale,
  output ovl_res_t           res,
  output logic [TAG_W-1:0]   res_idx
);

  logic [COORD_W-1:0]       mul_sx;
  logic [COORD_W-1:0]       mul_sy;
  logic [PROD_W-1:0]        hx_prod;
  logic [PROD_W-1:0]        hy_prod;
  logic [PROD_W-1:0]        q_hx;
  logic [PROD_W-1:0]        q_hy;
  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic                     st_valid;
  logic                     st_load;
  logic [TAG_W-1:0]         st_idx;
  logic [DIFF_W-1:0]        adx;
  logic [DIFF_W-1:0]        ady;
  logic [SUM_W-1:0]         sum_x;
  logic [SUM_W-1:0]         sum_y;
  logic                     fit_x;
  logic                     fit_y;

  // The query's half-extents go through the same multipliers in a load cycle.
  assign mul_sx = ctl.load_q ? query.sx : ent.sx;
  assign mul_sy = ctl.load_q ? query.sy : ent.sy;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
      st_load  <= 1'b0;
    end else begin
      st_valid <= ctl.valid;
      st_load  <= ctl.load_q;
    end
    hx_prod <= PROD_W'(mul_sx) * PROD_W'(x_scale);
    hy_prod <= PROD_W'(mul_sy) * PROD_W'(y_scale);
    dx      <= DIFF_W'(ent.px) - DIFF_W'(query.px);
    dy      <= DIFF_W'(ent.py) - DIFF_W'(query.py);
    st_idx  <= ent_idx;
    if (st_load) begin
      q_hx <= hx_prod;
      q_hy <= hy_prod;
    end
  end

  // Overlap on an axis holds when the centre distance is within the summed extents.
  always_comb begin
    adx   = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
    ady   = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
    sum_x = SUM_W'(hx_prod) + SUM_W'(q_hx);
    sum_y = SUM_W'(hy_prod) + SUM_W'(q_hy);
    fit_x = SUM_W'({adx, FRAC_W'(0)}) <= sum_x;
    fit_y = SUM_W'({ady, FRAC_W'(0)}) <= sum_y;
  end

  assign res.valid = st_valid;
  assign res.hit   = fit_x && fit_y;
  assign res_idx   = st_idx;

endmodule

// ===== rtl/aabb_collision_table_top.sv =====
// Top level of the box table with overlap search.
// Depends on aabb_ct_pkg, aabb_ct_ram, aabb_ct_ovl and the assertion macro header.
`include "aabb_collision_table_top_defines.svh"

// The block keeps an ordered table of up to TABLE_DEPTH boxes in a RAM and
// handles one request at a time. An add (tuser kind 0) appends the box; a full
// table answers status 1. A remove (kind 1) moves every later entry down by
// one, one entry per cycle through the RAM's single read port and single write
// port; an index at or beyond the count answers status 2. A find (kind 2)
// streams the entries from index 0 through the one shared multiplier pair and
// compare unit, one entry per cycle behind the RAM read register and the overlap
// unit's register, and stops at the first overlap. Kind 3 answers status 0.
// Configuration writes on the cfg port set the per-axis Q1.8 extent scales and
// should be made while no request is in flight. Results sit in an output
// register, so the next request is taken while the previous result waits on
// m_tready.
module aabb_collision_table_top import aabb_ct_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  // Request: tdata holds, from bit 0 up, index, pos_x, pos_y, size_x, size_y,
  // and two zero bits.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // tuser holds kind.
  input  logic [KIND_W-1:0]     s_tuser,
  // Result: tdata holds, from bit 0 up, status, hit, hit_index, entry_count.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  // Configuration writes: index 0 is x_extent_scale, index 1 y_extent_scale.
  input  logic                  cfg_we,
  input  logic                  cfg_addr,
  input  logic [SCALE_W-1:0]    cfg_data
);

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCAN,
    ST_SHIFT,
    ST_FIN
  } state_t;

  state_t               state;
  logic [CNT_W-1:0]     count;
  logic [SCALE_W-1:0]   x_scale;
  logic [SCALE_W-1:0]   y_scale;
  logic [CNT_W-1:0]     rd_ptr;
  logic [AW-1:0]        wr_ptr;
  logic                 rv;
  box_t                 q;
  logic [STATUS_W-1:0]  res_status;
  logic                 res_hit;
  logic [AW-1:0]        res_idx;

  logic                 in_acc;
  logic [KIND_W-1:0]    in_kind;
  logic [IDX_W-1:0]     in_idx;
  box_t                 in_box;
  logic                 scan_found;
  logic                 issue;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [BOX_W-1:0]     ram_wdata;
  logic [BOX_W-1:0]     ram_rdata;
  ovl_ctl_t             ovl_ctl;
  ovl_res_t             ovl_res;
  logic [AW-1:0]        ovl_idx;
  logic [AW-1:0]        ent_idx;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    in_acc    = s_tvalid && s_tready;
    in_kind   = s_tuser;
    in_idx    = s_tdata[5:0];
    in_box.px = s_tdata[21:6];
    in_box.py = s_tdata[37:22];
    in_box.sx = s_tdata[53:38];
    in_box.sy = s_tdata[69:54];

    scan_found = (state == ST_SCAN) && ovl_res.valid && ovl_res.hit;
    issue = ((state == ST_PREP) || (state == ST_SCAN) || (state == ST_SHIFT)) &&
            (rd_ptr < count) && !scan_found;

    // The add write comes straight from the request; the shift write copies
    // the entry read on the previous cycle one place down.
    ram_we    = 1'b0;
    ram_waddr = count[AW-1:0];
    ram_wdata = in_box;
    if (in_acc && (in_kind == KIND_ADD) && (count < CNT_W'(TABLE_DEPTH))) begin
      ram_we = 1'b1;
    end else if ((state == ST_SHIFT) && rv) begin
      ram_we    = 1'b1;
      ram_waddr = wr_ptr;
      ram_wdata = ram_rdata;
    end

    ovl_ctl.valid  = rv && (state == ST_SCAN);
    ovl_ctl.load_q = (state == ST_PREP);
  end

  aabb_ct_ram #(
    .WIDTH (BOX_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (issue),
    .raddr (rd_ptr[AW-1:0]),
    .rdata (ram_rdata)
  );

  // The index of the entry that arrives on the RAM output trails the read pointer.
  assign ent_idx = AW'(rd_ptr - CNT_W'(1));

  aabb_ct_ovl #(
    .TAG_W (AW)
  ) u_ovl (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ovl_ctl),
    .ent     (ram_rdata),
    .ent_idx (ent_idx),
    .query   (q),
    .x_scale (x_scale),
    .y_scale (y_scale),
    .res     (ovl_res),
    .res_idx (ovl_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      x_scale  <= X_SCALE_RESET;
      y_scale  <= Y_SCALE_RESET;
      rv       <= 1'b0;
      res_hit  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_X_SCALE: x_scale <= cfg_data;
          REG_Y_SCALE: y_scale <= cfg_data;
          default: ;
        endcase
      end

      rv <= issue;
      if (issue) begin
        rd_ptr <= rd_ptr + CNT_W'(1);
      end
      // In the finish state the result register is reloaded below instead.
      if (m_tvalid && m_tready && (state != ST_FIN)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            res_status <= STATUS_OK;
            res_hit    <= 1'b0;
            res_idx    <= '0;
            q          <= in_box;
            case (in_kind)
              KIND_ADD: begin
                if (count >= CNT_W'(TABLE_DEPTH)) begin
                  res_status <= STATUS_FULL;
                end else begin
                  count <= count + CNT_W'(1);
                end
                state <= ST_FIN;
              end
              KIND_REMOVE: begin
                if (32'(in_idx) >= 32'(count)) begin
                  res_status <= STATUS_RANGE;
                  state      <= ST_FIN;
                end else begin
                  rd_ptr <= CNT_W'(32'(in_idx) + 1);
                  wr_ptr <= AW'(in_idx);
                  state  <= ST_SHIFT;
                end
              end
              KIND_FIND: begin
                rd_ptr <= '0;
                state  <= ST_PREP;
              end
              default: state <= ST_FIN;
            endcase
          end
        end
        ST_PREP: begin
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          if (scan_found) begin
            res_hit <= 1'b1;
            res_idx <= ovl_idx;
            state   <= ST_FIN;
          end else if (!issue && !rv) begin
            state <= ST_FIN;
          end
        end
        ST_SHIFT: begin
          if (rv) begin
            wr_ptr <= wr_ptr + AW'(1);
          end
          if (!issue && !rv) begin
            count <= count - CNT_W'(1);
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {ECNT_W'(count), IDX_W'(res_idx), res_hit, res_status};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `AABB_ASSERT_IMP(a_count_max, 1'b1, count <= CNT_W'(TABLE_DEPTH), "count above table depth")
  `AABB_ASSERT_NXT(a_count_step, 1'b1,
    (count == $past(count)) || (count == $past(count) + CNT_W'(1)) ||
    (count == $past(count) - CNT_W'(1)), "count moved by more than one")
  `AABB_ASSERT_IMP(a_shift_range, (state == ST_SHIFT) && ram_we,
    32'(wr_ptr) + 1 < 32'(count), "shift write beyond the held entries")
  `AABB_ASSERT_IMP(a_hit_range, res_hit, 32'(res_idx) < 32'(count), "hit index not below count")

endmodule
